### hw/rtl/cor_pkg.sv
`default_nettype none
package cor_pkg;

   // register indexes on the csr channel
   typedef enum logic [1:0] {
      REG_HRES  = 2'd0,
      REG_VRES  = 2'd1,
      REG_PBITS = 2'd2,
      REG_SPARE = 2'd3
   } reg_index_type;

   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } op_type;

   localparam logic [11:0] HRES_RESET  = 12'd1024;
   localparam logic [11:0] VRES_RESET  = 12'd768;
   localparam logic [5:0]  PBITS_RESET = 6'd8;

   // midpoint decision constants
   localparam logic [31:0] DEC_INIT      = 32'd3;
   localparam logic [31:0] DEC_INC_KEEP  = 32'd6;
   localparam logic [31:0] DEC_INC_MOVE  = 32'd10;

   localparam int unsigned PIXELS_PER_STEP = 16;

endpackage
`default_nettype wire

### hw/rtl/cor_req_if.sv
`default_nettype none
interface cor_req_if;
   logic        valid;
   logic        ready;
   logic        op;
   logic [15:0] centre_x;
   logic [15:0] centre_y;
   logic [15:0] circle_radius;
   logic [31:0] draw_color;

   modport source (output valid, op, centre_x, centre_y, circle_radius, draw_color,
                   input ready);
   modport sink (input valid, op, centre_x, centre_y, circle_radius, draw_color,
                 output ready);
endinterface
`default_nettype wire

### hw/rtl/cor_rsp_if.sv
`default_nettype none
interface cor_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_x;
   logic [15:0] pixel_y;
   logic        visible;
   logic [25:0] byte_offset;
   logic [31:0] pixel_color;
   logic        last;
   logic        done_res;

   modport source (output valid, pixel_x, pixel_y, visible, byte_offset, pixel_color,
                   last, done_res, input ready);
   modport sink (input valid, pixel_x, pixel_y, visible, byte_offset, pixel_color,
                 last, done_res, output ready);
endinterface
`default_nettype wire

### hw/rtl/cor_csr_if.sv
`default_nettype none
interface cor_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  reg_index;
   logic [11:0] wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface
`default_nettype wire

### hw/rtl/circle_outline_rasterizer_core.sv
// circle outline rasterizer, midpoint circle walk
//
// req_bus: op=start latches centre, radius and color and produces nothing;
//    op=step produces sixteen pixel transfers on rsp_bus (eight octant points
//    before the decision update, eight after), the sixteenth with last set and
//    done_res set once the walk has passed the diagonal. a step with no circle
//    in progress produces a single transfer with last and done_res set.
// csr_bus: register writes (horizontal res, vertical res, bits per pixel),
//    always ready, only to be used while the block is idle.
// pixel path: the generator feeds the position stage, the row-multiply stage
//    and the output register, in that order.
// throughput: one pixel per cycle while the pipe is not held; the generator
//    emits one octant point per cycle and takes the next item with the last one.
// a new item is taken while the last pixels of the previous step are still in
//    the pipe; if rsp_bus.ready is low the whole pixel pipe holds.
// reset: registers return to their defaults, no circle in progress, pipe empty.
`default_nettype none
module circle_outline_rasterizer_core
   import cor_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   cor_req_if.sink    req_bus,
   cor_rsp_if.source  rsp_bus,
   cor_csr_if.sink    csr_bus
);

   // configuration registers
   logic [11:0] hres_ff;
   logic [11:0] vres_ff;
   logic [5:0]  pbits_ff;

   // walk state
   logic [15:0] cx_ff, cx_in;
   logic [15:0] cy_ff, cy_in;
   logic [31:0] dec_ff, dec_in;
   logic [17:0] p_ff, p_in;
   logic [17:0] q_ff, q_in;
   logic [31:0] color_ff, color_in;
   logic        active_ff, active_in;

   // pixel generator: snapshot of one step
   logic        gen_valid_ff, gen_valid_in;
   logic        gen_single_ff, gen_single_in;
   logic [3:0]  gen_cnt_ff, gen_cnt_in;
   logic [15:0] gen_cx_ff, gen_cy_ff;
   logic [15:0] gen_p0_ff, gen_q0_ff, gen_p1_ff, gen_q1_ff;
   logic [31:0] gen_color_ff;
   logic        gen_done_ff;

   // pixel pipe
   logic        s1_valid_ff;
   logic [15:0] s1_x_ff, s1_y_ff;
   logic        s1_vis_ff, s1_last_ff, s1_done_ff;
   logic [31:0] s1_color_ff;
   logic        s2_valid_ff;
   logic [15:0] s2_x_ff, s2_y_ff;
   logic        s2_vis_ff, s2_last_ff, s2_done_ff;
   logic [31:0] s2_color_ff;
   logic [25:0] s2_lin_ff;
   logic        out_valid_ff;

   logic        pipe_en;
   logic        gen_adv;
   logic        gen_last;
   logic        req_xfer;
   logic        is_step;

   // step arithmetic
   logic        dec_le_zero;
   logic [17:0] p_step, q_step;
   logic [31:0] pq_diff;
   logic [31:0] dec_step;
   logic        step_done;

   // pixel selection
   logic [15:0] sel_p, sel_q, off_a, off_b;
   logic [15:0] pix_x_in, pix_y_in;
   logic        pix_vis_in;
   logic [27:0] row_prod;
   logic [25:0] lin_in;
   logic [3:0]  bytes_pp;
   logic [6:0]  bits_round;
   logic [29:0] off_full;

   //---------------------------------------------------------------- handshakes
   // whole pipe moves when the output register is free or being drained
   assign pipe_en  = !out_valid_ff || rsp_bus.ready;
   assign gen_adv  = pipe_en && gen_valid_ff;
   assign gen_last = gen_single_ff || (gen_cnt_ff == 4'(PIXELS_PER_STEP - 1));

   // a new item may enter once the generator hands out its final pixel
   assign req_bus.ready = !gen_valid_ff || (gen_adv && gen_last);
   assign req_xfer      = req_bus.valid && req_bus.ready;
   assign is_step       = (req_bus.op == OP_STEP);

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hres_ff  <= HRES_RESET;
         vres_ff  <= VRES_RESET;
         pbits_ff <= PBITS_RESET;
      end else if (csr_bus.valid) begin
         unique case (reg_index_type'(csr_bus.reg_index))
            REG_HRES:  hres_ff  <= csr_bus.wdata;
            REG_VRES:  vres_ff  <= csr_bus.wdata;
            REG_PBITS: pbits_ff <= csr_bus.wdata[5:0];
            default: ;
         endcase
      end
   end

   //---------------------------------------------------------- midpoint update
   // decision <= 0 keeps the major offset, otherwise it moves one inward
   assign dec_le_zero = dec_ff[31] || (dec_ff == 32'd0);
   assign p_step      = p_ff + 18'd1;
   assign q_step      = dec_le_zero ? q_ff : q_ff - 18'd1;
   assign pq_diff     = {{14{p_step[17]}}, p_step} - {{14{q_step[17]}}, q_step};
   assign dec_step    = dec_le_zero
                        ? dec_ff + {{12{p_step[17]}}, p_step, 2'b00} + DEC_INC_KEEP
                        : dec_ff + {pq_diff[29:0], 2'b00} + DEC_INC_MOVE;
   assign step_done   = $signed(p_step) > $signed(q_step);

   always_comb begin
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      dec_in    = dec_ff;
      p_in      = p_ff;
      q_in      = q_ff;
      color_in  = color_ff;
      active_in = active_ff;
      if (req_xfer) begin
         if (!is_step) begin
            cx_in     = req_bus.centre_x;
            cy_in     = req_bus.centre_y;
            color_in  = req_bus.draw_color;
            dec_in    = DEC_INIT - {15'd0, req_bus.circle_radius, 1'b0};
            p_in      = 18'd0;
            q_in      = {2'b00, req_bus.circle_radius};
            active_in = 1'b1;
         end else if (active_ff) begin
            p_in      = p_step;
            q_in      = q_step;
            dec_in    = dec_step;
            active_in = !step_done;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff     <= '0;
         cy_ff     <= '0;
         dec_ff    <= '0;
         p_ff      <= '0;
         q_ff      <= '0;
         color_ff  <= '0;
         active_ff <= 1'b0;
      end else begin
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         dec_ff    <= dec_in;
         p_ff      <= p_in;
         q_ff      <= q_in;
         color_ff  <= color_in;
         active_ff <= active_in;
      end
   end

   //------------------------------------------------------------ pixel generator
   always_comb begin
      gen_valid_in  = gen_valid_ff;
      gen_single_in = gen_single_ff;
      gen_cnt_in    = gen_cnt_ff;
      if (req_xfer && is_step) begin
         gen_valid_in  = 1'b1;
         gen_single_in = !active_ff;
         gen_cnt_in    = 4'd0;
      end else if (gen_adv) begin
         if (gen_last) begin
            gen_valid_in = 1'b0;
         end else begin
            gen_cnt_in = gen_cnt_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_valid_ff  <= 1'b0;
         gen_single_ff <= 1'b0;
         gen_cnt_ff    <= '0;
      end else begin
         gen_valid_ff  <= gen_valid_in;
         gen_single_ff <= gen_single_in;
         gen_cnt_ff    <= gen_cnt_in;
      end
   end

   // snapshot of points before and after the update for the sixteen pixels
   always_ff @(posedge clock) begin
      if (req_xfer && is_step) begin
         gen_cx_ff    <= cx_ff;
         gen_cy_ff    <= cy_ff;
         gen_p0_ff    <= p_ff[15:0];
         gen_q0_ff    <= q_ff[15:0];
         gen_p1_ff    <= p_step[15:0];
         gen_q1_ff    <= q_step[15:0];
         gen_color_ff <= color_ff;
         gen_done_ff  <= step_done;
      end
   end

   // count bit 3 picks before/after update, bit 2 swaps axes,
   // bit 0 negates the column offset, bit 1 the row offset
   always_comb begin
      sel_p = gen_cnt_ff[3] ? gen_p1_ff : gen_p0_ff;
      sel_q = gen_cnt_ff[3] ? gen_q1_ff : gen_q0_ff;
      off_a = gen_cnt_ff[2] ? sel_q : sel_p;
      off_b = gen_cnt_ff[2] ? sel_p : sel_q;
      if (gen_single_ff) begin
         pix_x_in   = 16'd0;
         pix_y_in   = 16'd0;
         pix_vis_in = 1'b0;
      end else begin
         pix_x_in   = gen_cnt_ff[0] ? gen_cx_ff - off_a : gen_cx_ff + off_a;
         pix_y_in   = gen_cnt_ff[1] ? gen_cy_ff - off_b : gen_cy_ff + off_b;
         pix_vis_in = (pix_x_in < {4'd0, hres_ff}) && (pix_y_in < {4'd0, vres_ff});
      end
   end

   //---------------------------------------------------------------- pixel pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff  <= gen_valid_ff;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   // stage 1: position, visibility
   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_x_ff     <= pix_x_in;
         s1_y_ff     <= pix_y_in;
         s1_vis_ff   <= pix_vis_in;
         s1_color_ff <= gen_single_ff ? 32'd0 : gen_color_ff;
         s1_last_ff  <= gen_last;
         s1_done_ff  <= gen_single_ff || (gen_last && gen_done_ff);
      end
   end

   // stage 2: linear pixel index, row times stride plus column
   assign row_prod = 28'(hres_ff) * 28'(s1_y_ff);
   assign lin_in   = row_prod[25:0] + {10'd0, s1_x_ff};

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s2_x_ff     <= s1_x_ff;
         s2_y_ff     <= s1_y_ff;
         s2_vis_ff   <= s1_vis_ff;
         s2_color_ff <= s1_color_ff;
         s2_last_ff  <= s1_last_ff;
         s2_done_ff  <= s1_done_ff;
         s2_lin_ff   <= lin_in;
      end
   end

   // stage 3: scale by bytes per pixel, offset only for visible pixels
   assign bits_round = {1'b0, pbits_ff} + 7'd7;
   assign bytes_pp   = bits_round[6:3];
   assign off_full   = 30'(s2_lin_ff) * 30'(bytes_pp);

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         rsp_bus.pixel_x     <= s2_x_ff;
         rsp_bus.pixel_y     <= s2_y_ff;
         rsp_bus.visible     <= s2_vis_ff;
         rsp_bus.byte_offset <= s2_vis_ff ? off_full[25:0] : 26'd0;
         rsp_bus.pixel_color <= s2_color_ff;
         rsp_bus.last        <= s2_last_ff;
         rsp_bus.done_res    <= s2_done_ff;
      end
   end

   assign rsp_bus.valid = out_valid_ff;

endmodule
`default_nettype wire

### test/tb_top.sv
`default_nettype none
module tb_top;
   import cor_pkg::*;

   // one input item as it travels on the request channel
   typedef struct packed {
      op_type      op;
      logic [15:0] centre_x;
      logic [15:0] centre_y;
      logic [15:0] circle_radius;
      logic [31:0] draw_color;
   } req_item_type;

   // one pixel as it travels on the response channel
   typedef struct packed {
      logic [15:0] pixel_x;
      logic [15:0] pixel_y;
      logic        visible;
      logic [25:0] byte_offset;
      logic [31:0] pixel_color;
      logic        last;
      logic        done_res;
   } pixel_type;

   // directed stimulus row; known marks a row whose response is typed in below
   typedef struct packed {
      op_type      op;
      logic [15:0] centre_x;
      logic [15:0] centre_y;
      logic [15:0] circle_radius;
      logic [31:0] draw_color;
      logic        known;
      pixel_type   known_px;
   } directed_row_type;

   // a step with no circle in progress gives this single pixel
   localparam pixel_type IDLE_DONE = '{16'h0, 16'h0, 1'b0, 26'h0, 32'h0, 1'b1, 1'b1};
   localparam pixel_type NO_PIXEL  = '0;

   localparam int DIRECTED_COUNT = 25;
   localparam directed_row_type DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
      // step right after reset, nothing in progress
      '{OP_STEP,  16'hffff, 16'hffff, 16'hffff, 32'hffffffff, 1'b1, IDLE_DONE},
      // zero radius, finishes on its first step
      '{OP_START, 16'd100,  16'd100,  16'd0,    32'hffffffff, 1'b0, NO_PIXEL},
      '{OP_STEP,  16'h0,    16'h0,    16'h0,    32'h0,        1'b0, NO_PIXEL},
      '{OP_STEP,  16'h0,    16'h0,    16'h0,    32'h0,        1'b1, IDLE_DONE},
      // centre at the origin, the left and top octants wrap around
      '{OP_START, 16'h0,    16'h0,    16'd5,    32'h0,        1'b0, NO_PIXEL},
      '{OP_STEP,  16'h1234, 16'h5678, 16'h9abc, 32'hdeadbeef, 1'b0, NO_PIXEL},
      '{OP_STEP,  16'h0,    16'h0,    16'h0,    32'h0,        1'b0, NO_PIXEL},
      // all-ones start abandons the circle above
      '{OP_START, 16'hffff, 16'hffff, 16'hffff, 32'ha5a5a5a5, 1'b0, NO_PIXEL},
      '{OP_STEP,  16'hffff, 16'hffff, 16'hffff, 32'hffffffff, 1'b0, NO_PIXEL},
      '{OP_STEP,  16'h0,    16'h0,    16'h0,    32'h0,        1'b0, NO_PIXEL},
      // corner of the default screen, half the octants fall outside
      '{OP_START, 16'd1023, 16'd767,  16'd1,    32'h12345678, 1'b0, NO_PIXEL},
      '{OP_STEP,  16'h0,    16'h0,    16'h0,    32'h0,        1'b0, NO_PIXEL},
      '{OP_STEP,  16'h0,    16'h0,    16'h0,    32'h0,        1'b0, NO_PIXEL},
      // radius three runs to completion in three steps
      '{OP_START, 16'd512,  16'd384,  16'd3,    32'h0f0f0f0f, 1'b0, NO_PIXEL},
      '{OP_STEP,  16'h0,    16'h0,    16'h0,    32'h0,        1'b0, NO_PIXEL},
      '{OP_STEP,  16'h0,    16'h0,    16'h0,    32'h0,        1'b0, NO_PIXEL},
      '{OP_STEP,  16'h0,    16'h0,    16'h0,    32'h0,        1'b0, NO_PIXEL},
      '{OP_STEP,  16'hffff, 16'hffff, 16'hffff, 32'hffffffff, 1'b1, IDLE_DONE},
      // msb of the radius, decision starts far negative
      '{OP_START, 16'h0,    16'h0,    16'h8000, 32'h0,        1'b0, NO_PIXEL},
      '{OP_STEP,  16'h0,    16'h0,    16'h0,    32'h0,        1'b0, NO_PIXEL},
      '{OP_START, 16'hffff, 16'h0,    16'd2,    32'hffff0000, 1'b0, NO_PIXEL},
      '{OP_STEP,  16'h0,    16'h0,    16'h0,    32'h0,        1'b0, NO_PIXEL},
      '{OP_STEP,  16'h0,    16'h0,    16'h0,    32'h0,        1'b0, NO_PIXEL},
      '{OP_START, 16'h5555, 16'haaaa, 16'haaaa, 32'h5555aaaa, 1'b0, NO_PIXEL},
      '{OP_STEP,  16'haaaa, 16'h5555, 16'h5555, 32'haaaa5555, 1'b0, NO_PIXEL}
   };

   // register settings walked between phases: unit, maximum, zero screen,
   // oversize pixel with offset truncation, zero bytes per pixel, odd sizes
   localparam int SETTING_COUNT = 6;
   localparam logic [11:0] SETTING_HRES  [0:SETTING_COUNT-1] =
      '{12'd1, 12'd4095, 12'd0, 12'd4095, 12'd640, 12'd37};
   localparam logic [11:0] SETTING_VRES  [0:SETTING_COUNT-1] =
      '{12'd1, 12'd4095, 12'd0, 12'd4095, 12'd480, 12'd23};
   localparam logic [5:0]  SETTING_PBITS [0:SETTING_COUNT-1] =
      '{6'd1, 6'd32, 6'd8, 6'd63, 6'd0, 6'd24};

   localparam int FIRST_RANDOM_ITEMS = 30;
   localparam int PHASE_ITEMS        = 18;
   localparam int HOLD_CYCLES        = 400;
   localparam int SETTLE_CYCLES      = 8;

   logic clock;
   logic reset;

   cor_req_if req_chan ();
   cor_rsp_if rsp_chan ();
   cor_csr_if csr_chan ();

   circle_outline_rasterizer_core uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_chan),
      .rsp_bus (rsp_chan),
      .csr_bus (csr_chan)
   );

   // ---------------------------------------------------------------
   // circle walk predictor: own copy of registers and walk state
   // ---------------------------------------------------------------
   logic [11:0] screen_width;
   logic [11:0] screen_height;
   logic [5:0]  pixel_depth;
   logic [15:0] walk_cx;
   logic [15:0] walk_cy;
   logic [31:0] walk_decision;
   int          walk_minor;
   int          walk_major;
   logic [31:0] walk_color;
   bit          walk_active;

   // pixels still owed by the block, oldest first
   pixel_type pending_pixels [$];
   int        fail_count;

   // sender burst bookkeeping and the one-time receiver hold-off
   int burst_left;
   bit hold_request;
   bit hold_served;

   function automatic pixel_type place_pixel(input logic [15:0] px, input logic [15:0] py);
      pixel_type   pix;
      logic [63:0] bytes;
      logic [63:0] offset;
      pix = '0;
      pix.pixel_x = px;
      pix.pixel_y = py;
      pix.visible = (px < screen_width) && (py < screen_height);
      // bytes per pixel rounded up, zero bits gives zero bytes
      bytes = (64'(pixel_depth) + 64'd7) >> 3;
      if (pix.visible) begin
         offset = (64'(px) + 64'(screen_width) * 64'(py)) * bytes;
         pix.byte_offset = offset[25:0];
      end
      pix.pixel_color = walk_color;
      return pix;
   endfunction

   // eight symmetric points of the current (P,Q), in the block's order
   function automatic void push_octants(ref pixel_type dst [$]);
      logic [15:0] p16;
      logic [15:0] q16;
      p16 = walk_minor[15:0];
      q16 = walk_major[15:0];
      dst.push_back(place_pixel(walk_cx + p16, walk_cy + q16));
      dst.push_back(place_pixel(walk_cx - p16, walk_cy + q16));
      dst.push_back(place_pixel(walk_cx + p16, walk_cy - q16));
      dst.push_back(place_pixel(walk_cx - p16, walk_cy - q16));
      dst.push_back(place_pixel(walk_cx + q16, walk_cy + p16));
      dst.push_back(place_pixel(walk_cx - q16, walk_cy + p16));
      dst.push_back(place_pixel(walk_cx + q16, walk_cy - p16));
      dst.push_back(place_pixel(walk_cx - q16, walk_cy - p16));
   endfunction

   function automatic void rasterize_item(input req_item_type it, ref pixel_type dst [$]);
      pixel_type idle_px;
      if (it.op == OP_START) begin
         // a start while a circle is in progress simply abandons it
         walk_cx       = it.centre_x;
         walk_cy       = it.centre_y;
         walk_color    = it.draw_color;
         walk_decision = DEC_INIT - 32'd2 * 32'(it.circle_radius);
         walk_minor    = 0;
         walk_major    = int'(it.circle_radius);
         walk_active   = 1'b1;
      end else if (!walk_active) begin
         idle_px = '0;
         idle_px.last = 1'b1;
         idle_px.done_res = 1'b1;
         dst.push_back(idle_px);
      end else begin
         push_octants(dst);
         walk_minor++;
         // non-positive decision keeps Q, positive moves Q inward
         if (walk_decision[31] || walk_decision == 32'd0) begin
            walk_decision = walk_decision + 32'(4 * walk_minor) + DEC_INC_KEEP;
         end else begin
            walk_major--;
            walk_decision = walk_decision + 32'(4 * (walk_minor - walk_major)) + DEC_INC_MOVE;
         end
         push_octants(dst);
         dst[$].last = 1'b1;
         if (walk_minor > walk_major) begin
            dst[$].done_res = 1'b1;
            walk_active = 1'b0;
         end
      end
   endfunction

   // ---------------------------------------------------------------
   // clock and limit
   // ---------------------------------------------------------------
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // generous bound, many times the slowest legal run
   initial begin
      #3000000;
      $display("[circle_outline_rasterizer_core] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------
   // request side: bursts of transfers with random gaps
   // ---------------------------------------------------------------
   task automatic send_item(input req_item_type it, input bit known, input pixel_type known_px);
      pixel_type fresh [$];
      int        gap;
      if (burst_left == 0) begin
         // most bursts are preceded by a gap, some run straight on
         if ($urandom_range(0, 4) != 0) begin
            req_chan.valid <= 1'b0;
            gap = $urandom_range(1, 20);
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 8);
      end
      req_chan.valid         <= 1'b1;
      req_chan.op            <= it.op;
      req_chan.centre_x      <= it.centre_x;
      req_chan.centre_y      <= it.centre_y;
      req_chan.circle_radius <= it.circle_radius;
      req_chan.draw_color    <= it.draw_color;
      do @(posedge clock); while (!req_chan.ready);
      // transfer taken at this edge, predict right away
      rasterize_item(it, fresh);
      if (known) begin
         pending_pixels.push_back(known_px);
      end else begin
         foreach (fresh[i]) pending_pixels.push_back(fresh[i]);
      end
      burst_left--;
   endtask

   function automatic req_item_type random_step();
      req_item_type it;
      // payload of a step is ignored, still toggle it
      it.op            = OP_STEP;
      it.centre_x      = 16'($urandom);
      it.centre_y      = 16'($urandom);
      it.circle_radius = 16'($urandom);
      it.draw_color    = $urandom;
      return it;
   endfunction

   function automatic req_item_type random_start(input int max_radius);
      req_item_type it;
      it.op = OP_START;
      // mostly around the visible area so both sides of each edge show up
      if ($urandom_range(0, 3) == 0) begin
         it.centre_x = 16'($urandom);
         it.centre_y = 16'($urandom);
      end else begin
         it.centre_x = 16'($urandom_range(0, int'(screen_width) + 40));
         it.centre_y = 16'($urandom_range(0, int'(screen_height) + 40));
      end
      it.circle_radius = 16'($urandom_range(0, max_radius));
      it.draw_color    = $urandom;
      return it;
   endfunction

   // mostly whole circles, then abandoned walks, stray steps and lone starts
   task automatic random_traffic(input int item_goal);
      int sent;
      int kind;
      int extra;
      int max_radius;
      sent = 0;
      while (sent < item_goal) begin
         kind = $urandom_range(0, 99);
         if (kind < 70) begin
            max_radius = ($urandom_range(0, 7) == 0) ? 40 : 16;
            send_item(random_start(max_radius), 1'b0, NO_PIXEL);
            sent++;
            while (walk_active) begin
               send_item(random_step(), 1'b0, NO_PIXEL);
               sent++;
            end
         end else if (kind < 85) begin
            send_item(random_start(65535), 1'b0, NO_PIXEL);
            sent++;
            extra = $urandom_range(0, 3);
            repeat (extra) begin
               send_item(random_step(), 1'b0, NO_PIXEL);
               sent++;
            end
         end else if (kind < 95) begin
            extra = $urandom_range(1, 2);
            repeat (extra) begin
               send_item(random_step(), 1'b0, NO_PIXEL);
               sent++;
            end
         end else begin
            send_item(random_start(65535), 1'b0, NO_PIXEL);
            sent++;
         end
      end
   endtask

   // drop valid, drain every owed pixel, then let the pipe empty
   task automatic settle();
      req_chan.valid <= 1'b0;
      burst_left = 0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------
   // register writes, only while the block is idle
   // ---------------------------------------------------------------
   task automatic csr_write(input reg_index_type index, input logic [11:0] value);
      csr_chan.valid     <= 1'b1;
      csr_chan.reg_index <= index;
      csr_chan.wdata     <= value;
      do @(posedge clock); while (!csr_chan.ready);
      case (index)
         REG_HRES:  screen_width  = value;
         REG_VRES:  screen_height = value;
         REG_PBITS: pixel_depth   = value[5:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [11:0] width, input logic [11:0] height,
                                input logic [5:0] bits);
      csr_write(REG_HRES, width);
      csr_write(REG_VRES, height);
      // upper data bits land outside the pixel_bits field
      csr_write(REG_PBITS, {6'($urandom), bits});
      // spare index must be ignored
      csr_write(REG_SPARE, 12'($urandom));
      csr_chan.valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // response side: changing stall pattern plus one long hold-off
   // ---------------------------------------------------------------
   initial begin : rsp_receiver
      int mode;
      int mode_left;
      int tick;
      rsp_chan.ready = 1'b0;
      mode = 0;
      mode_left = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_served) begin
            // hold long enough for the pipe to back up into the request side
            hold_served = 1'b1;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (mode_left == 0) begin
            mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         tick++;
         case (mode)
            0: rsp_chan.ready <= 1'b1;
            1: rsp_chan.ready <= 1'($urandom_range(0, 1));
            2: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_chan.ready <= ((tick % 5) >= 2);
         endcase
      end
   end

   // ---------------------------------------------------------------
   // pixel checker
   // ---------------------------------------------------------------
   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      pixel_type want_px;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_pixels.size() == 0) begin
            $error("pixel transfer with nothing owed: x=%0h y=%0h",
                   rsp_chan.pixel_x, rsp_chan.pixel_y);
            fail_count++;
         end else begin
            want_px = pending_pixels.pop_front();
            check_field("pixel_x",     32'(want_px.pixel_x),     32'(rsp_chan.pixel_x));
            check_field("pixel_y",     32'(want_px.pixel_y),     32'(rsp_chan.pixel_y));
            check_field("visible",     32'(want_px.visible),     32'(rsp_chan.visible));
            check_field("byte_offset", 32'(want_px.byte_offset), 32'(rsp_chan.byte_offset));
            check_field("pixel_color", want_px.pixel_color,      rsp_chan.pixel_color);
            check_field("last",        32'(want_px.last),        32'(rsp_chan.last));
            check_field("done_res",    32'(want_px.done_res),    32'(rsp_chan.done_res));
         end
      end
   end

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin : stimulus
      req_item_type row_item;
      int           s;
      fail_count   = 0;
      burst_left   = 0;
      hold_request = 1'b0;
      hold_served  = 1'b0;

      req_chan.valid         = 1'b0;
      req_chan.op            = OP_START;
      req_chan.centre_x      = '0;
      req_chan.centre_y      = '0;
      req_chan.circle_radius = '0;
      req_chan.draw_color    = '0;
      csr_chan.valid         = 1'b0;
      csr_chan.reg_index     = REG_HRES;
      csr_chan.wdata         = '0;

      // predictor starts from the reset defaults
      screen_width   = HRES_RESET;
      screen_height  = VRES_RESET;
      pixel_depth    = PBITS_RESET;
      walk_cx        = '0;
      walk_cy        = '0;
      walk_decision  = '0;
      walk_minor     = 0;
      walk_major     = 0;
      walk_color     = '0;
      walk_active    = 1'b0;

      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed table at the reset settings
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row_item.op            = DIRECTED_ROWS[i].op;
         row_item.centre_x      = DIRECTED_ROWS[i].centre_x;
         row_item.centre_y      = DIRECTED_ROWS[i].centre_y;
         row_item.circle_radius = DIRECTED_ROWS[i].circle_radius;
         row_item.draw_color    = DIRECTED_ROWS[i].draw_color;
         send_item(row_item, DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].known_px);
      end

      // first random phase carries the long receiver hold-off
      hold_request = 1'b1;
      random_traffic(FIRST_RANDOM_ITEMS);

      // register settings, the last one picked at random
      for (s = 0; s <= SETTING_COUNT; s++) begin
         settle();
         if (s < SETTING_COUNT) begin
            apply_setting(SETTING_HRES[s], SETTING_VRES[s], SETTING_PBITS[s]);
         end else begin
            apply_setting(12'($urandom_range(1, 4095)), 12'($urandom_range(1, 4095)),
                          6'($urandom_range(1, 32)));
         end
         random_traffic(PHASE_ITEMS);
      end

      // drain and give the pipe time to show any stray pixel
      settle();
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending_pixels.size() == 0) begin
         $display("[circle_outline_rasterizer_core] OK");
      end else begin
         $display("[circle_outline_rasterizer_core] ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire

### filelist.f
hw/rtl/cor_pkg.sv
hw/rtl/cor_req_if.sv
hw/rtl/cor_rsp_if.sv
hw/rtl/cor_csr_if.sv
hw/rtl/circle_outline_rasterizer_core.sv
test/tb_top.sv
